// File: rtl/lgp_pkg.sv
// Package for the linear GP register machine: opcodes, controller states,
// register count, and the command/status structs between controller and datapath.
package lgp_pkg;

  typedef enum logic [3:0] {
    OP_LDP  = 4'd0,
    OP_LDC  = 4'd1,
    OP_NEG  = 4'd2,
    OP_ADD  = 4'd3,
    OP_SUB  = 4'd4,
    OP_MUL  = 4'd5,
    OP_DIV  = 4'd6,
    OP_SQR  = 4'd7,
    OP_ROOT = 4'd8,
    OP_COND = 4'd9,
    OP_NOP  = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_ITER,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Register file depth; register indexes are 4 bits wide.
  localparam int NUM_REGS = 16;

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam int unsigned ITER_STEPS = 32;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;   // latch the input transaction
    logic read;      // read source registers
    logic exec;      // start the operation
    logic iter;      // one step of the serial divide or root
    logic write;     // commit result and update skip flag
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic serial;    // current op uses the serial unit
    logic skip;      // item is skipped
  } dp_sts_t;

endpackage

// File: rtl/lgp_ctrl.sv
// Controller state machine for the register machine.
// Depends on lgp_pkg.
module lgp_ctrl
  import lgp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_fire,
  input  dp_sts_t  sts,
  output logic     in_ready,
  output logic     out_valid,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_READ;
      ST_READ:  state_nxt = sts.skip ? ST_WRITE : ST_EXEC;
      ST_EXEC: begin
        cnt_nxt   = '0;
        state_nxt = sts.serial ? ST_ITER : ST_WRITE;
      end
      ST_ITER: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(ITER_STEPS - 1)) state_nxt = ST_WRITE;
      end
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT:   if (out_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      ST_IDLE:  begin in_ready = 1'b1; cmd.capture = in_fire; end
      ST_READ:  cmd.read = 1'b1;
      ST_EXEC:  cmd.exec = 1'b1;
      ST_ITER:  cmd.iter = 1'b1;
      ST_WRITE: cmd.write = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default:  ;
    endcase
  end

endmodule

// File: rtl/lgp_dpath.sv
// Datapath: register file, ALU, multiplier and serial divide/root unit.
// Depends on lgp_pkg.
module lgp_dpath
  import lgp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  input  logic [3:0]         in_cmd,
  input  logic [3:0]         in_dest,
  input  logic [3:0]         in_src_a,
  input  logic [3:0]         in_src_b,
  input  logic signed [31:0] in_opv,
  output dp_sts_t            sts,
  output logic signed [31:0] write_value,
  output logic               wrote,
  output logic               skipped
);

  localparam int IW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic signed [31:0] rf_r [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic skip_r;

  logic [3:0] op_r, dst_r, sa_r, sb_r;
  logic signed [31:0] opv_r, a_r, b_r, t_r, res_val;
  logic signed [63:0] prod_r;
  logic [63:0] rem_r, quo_r, den_r, root_r, x_r;
  logic neg_r, wr_en;
  logic signed [31:0] outv_r;
  logic outw_r, outs_r;
  logic [5:0] ser_cnt_r;

  // Register read with out-of-range and never-written indexes reading zero.
  function automatic logic signed [31:0] rdreg(input logic [3:0] idx,
      input logic [NUM_REGS-1:0] v, input logic signed [31:0] d);
    rdreg = (32'(idx) < NUM_REGS && v[idx[IW-1:0]]) ? d : 32'sd0;
  endfunction

  logic signed [31:0] ra, rb, rt;
  assign ra = rdreg(sa_r, vld_r, rf_r[sa_r[IW-1:0]]);
  assign rb = rdreg(sb_r, vld_r, rf_r[sb_r[IW-1:0]]);
  assign rt = rdreg(dst_r, vld_r, rf_r[dst_r[IW-1:0]]);

  assign sts.serial = (op_r == OP_DIV && b_r != 0) || op_r == OP_ROOT;
  assign sts.skip   = skip_r;

  // Control state: valid bits and pending skip.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      skip_r <= 1'b0;
    end else if (cmd.write) begin
      if (skip_r) skip_r <= 1'b0;
      else if (op_r == OP_COND) skip_r <= (t_r > -Q_ONE) && (t_r < Q_ONE);
      if (!skip_r && wr_en) vld_r[dst_r[IW-1:0]] <= 1'b1;
    end
  end

  // Arithmetic for the short operations.
  logic signed [32:0] ext_sum, ext_dif, ext_neg;
  logic signed [47:0] pf;
  logic signed [31:0] mulr;
  assign ext_sum = 33'(a_r) + 33'(b_r);
  assign ext_dif = 33'(a_r) - 33'(b_r);
  assign ext_neg = -33'(a_r);
  assign pf   = 48'(prod_r >>> 16);
  assign mulr = (pf > 48'sd2147483647 || pf < -48'sd2147483648) ? Q_ONE : 32'(pf);

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) sat33 = 32'sh7fffffff;
    else if (v < -33'sd2147483648) sat33 = 32'sh80000000;
    else sat33 = v[31:0];
  endfunction

  // Top bit of the root trial value.
  logic [63:0] rbit;
  assign rbit = 64'd1 << 2*(ITER_STEPS - 1);

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_cmd; dst_r <= in_dest; sa_r <= in_src_a; sb_r <= in_src_b;
      opv_r <= in_opv;
    end
    if (cmd.read) begin
      a_r <= ra; b_r <= rb; t_r <= rt;
    end
    if (cmd.exec) begin
      prod_r <= (op_r == OP_SQR) ? 64'(a_r) * 64'(a_r) : 64'(a_r) * 64'(b_r);
      neg_r  <= a_r[31] ^ b_r[31];
      rem_r  <= '0;
      quo_r  <= {16'd0, (a_r[31] ? 32'(-a_r) : 32'(a_r)), 16'd0};
      den_r  <= {32'd0, (b_r[31] ? 32'(-b_r) : 32'(b_r))};
      x_r    <= {16'd0, (a_r[31] ? 32'(-a_r) : 32'(a_r)), 16'd0};
      root_r <= '0;
    end
    if (cmd.iter) begin
      // Divide: shift two quotient bits per step over 32 steps (64-bit dividend).
      begin : dv
        logic [63:0] r1, q1, r2, q2;
        r1 = {rem_r[62:0], quo_r[63]}; q1 = {quo_r[62:0], 1'b0};
        if (r1 >= den_r) begin r1 = r1 - den_r; q1[0] = 1'b1; end
        r2 = {r1[62:0], q1[63]}; q2 = {q1[62:0], 1'b0};
        if (r2 >= den_r) begin r2 = r2 - den_r; q2[0] = 1'b1; end
        rem_r <= r2; quo_r <= q2;
      end
      // Root: one result bit per step.
      begin : rt_step
        logic [63:0] bitv, trial;
        bitv  = rbit >> (2 * ser_cnt_r);
        trial = root_r + bitv;
        if (x_r >= trial) begin
          x_r <= x_r - trial; root_r <= (root_r >> 1) + bitv;
        end else begin
          root_r <= root_r >> 1;
        end
      end
    end
    if (cmd.write) begin
      outs_r <= skip_r;
      outw_r <= !skip_r && wr_en;
      outv_r <= (!skip_r && wr_en) ? res_val : 32'sd0;
      if (!skip_r && wr_en) rf_r[dst_r[IW-1:0]] <= res_val;
    end
  end

  // Root step counter kept locally, mirroring the controller's iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) ser_cnt_r <= '0;
    else if (cmd.exec) ser_cnt_r <= '0;
    else if (cmd.iter) ser_cnt_r <= ser_cnt_r + 6'd1;
  end

  // Final result selection.
  logic [64:0] qs;
  always_comb begin
    qs      = neg_r ? -{1'b0, quo_r} : {1'b0, quo_r};
    wr_en   = 1'b1;
    res_val = 32'sd0;
    case (op_r)
      OP_LDP, OP_LDC: res_val = opv_r;
      OP_NEG: res_val = sat33(ext_neg);
      OP_ADD: res_val = sat33(ext_sum);
      OP_SUB: res_val = sat33(ext_dif);
      OP_MUL, OP_SQR: res_val = mulr;
      OP_DIV: begin
        if (b_r == 0) res_val = Q_ONE;
        else if (!neg_r && quo_r > 64'h7fffffff) res_val = 32'sh7fffffff;
        else if (neg_r && quo_r > 64'h80000000) res_val = 32'sh80000000;
        else res_val = qs[31:0];
      end
      OP_ROOT: res_val = root_r[31:0];
      default: wr_en = 1'b0;
    endcase
    if (32'(dst_r) >= NUM_REGS) wr_en = 1'b0;
  end

  assign write_value = outv_r;
  assign wrote       = outw_r;
  assign skipped     = outs_r;

endmodule

// File: rtl/lgp_register_machine_step.sv
// Top level of the linear GP register machine step block.
// Depends on lgp_pkg, lgp_ctrl and lgp_dpath.
//
//  Channel | Direction | Contents
//  in_     | slave     | one instruction per transaction
//  out_    | master    | one result per transaction
//
// An item runs the read, execute, write and output states; a divide by nonzero
// or a root adds the serial unit's 32 steps before write, and a skipped item
// goes from read to write. The next instruction waits until out_tready takes the result.
// Synchronous active-low reset clears the register file valid bits and the
// pending skip; registers read as zero until written.
module lgp_register_machine_step
  import lgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] cmd, [7:4] dest_reg, [11:8] src_a, [15:12] src_b,
  // [47:16] operand_value
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] write_value, [32] wrote, [33] skipped, rest zero
  output logic [39:0] out_tdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [31:0] wv;
  logic wr, sk;

  lgp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .out_fire(out_tvalid && out_tready),
    .sts(sts), .in_ready(in_tready), .out_valid(out_tvalid), .cmd(cmd)
  );

  lgp_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_cmd(in_tdata[3:0]), .in_dest(in_tdata[7:4]),
    .in_src_a(in_tdata[11:8]), .in_src_b(in_tdata[15:12]),
    .in_opv(in_tdata[47:16]), .sts(sts),
    .write_value(wv), .wrote(wr), .skipped(sk)
  );

  assign out_tdata = {6'd0, sk, wr, wv};

endmodule

// File: sim/lgp_step_checker.sv
// Checker for the register machine step block: watches both stream channels,
// predicts each result from the instruction transactions, and compares.
// Depends on lgp_pkg for the opcode enum, the register count and Q_ONE.
module lgp_step_checker
  import lgp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic        skipped;
    logic        wrote;
    logic [31:0] write_value;
  } step_result_t;

  logic signed [31:0] regs [NUM_REGS];
  logic               skip_armed;
  step_result_t       expected_results [$];

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Q16.16 product, floor rounding; out of range gives 1.0.
  function automatic longint fixed_product(longint a, longint b);
    longint p;
    longint r;
    p = a * b;
    r = p >>> 16;
    if (r > S32_MAX || r < S32_MIN) return Q_ONE;
    return r;
  endfunction

  function automatic longint int_root(longint x);
    longint res;
    longint bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > x) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint read_reg(logic [3:0] idx);
    return (idx < NUM_REGS) ? longint'(regs[idx]) : 0;
  endfunction

  // Executes one instruction on the checker's register copy.
  function automatic step_result_t execute_instruction(logic [47:0] d);
    op_t           op;
    logic [3:0]    dst;
    longint        a;
    longint        b;
    longint        opv;
    longint        val;
    longint        t;
    logic          wr;
    step_result_t  r;
    op = op_t'(d[3:0]);
    dst = d[7:4];
    a = read_reg(d[11:8]);
    b = read_reg(d[15:12]);
    opv = longint'($signed(d[47:16]));
    val = 0;
    wr = 1'b1;
    r = '0;
    if (skip_armed) begin
      skip_armed = 1'b0;
      r.skipped = 1'b1;
      return r;
    end
    case (op)
      OP_LDP, OP_LDC: val = opv;
      OP_NEG: val = clamp32(-a);
      OP_ADD: val = clamp32(a + b);
      OP_SUB: val = clamp32(a - b);
      OP_MUL: val = fixed_product(a, b);
      OP_DIV: val = (b == 0) ? longint'(Q_ONE) : clamp32((a * 65536) / b);
      OP_SQR: val = fixed_product(a, a);
      OP_ROOT: val = int_root((a < 0 ? -a : a) <<< 16);
      OP_COND: begin
        t = read_reg(dst);
        if (t > -longint'(Q_ONE) && t < longint'(Q_ONE)) skip_armed = 1'b1;
        wr = 1'b0;
      end
      default: wr = 1'b0;
    endcase
    if (wr && dst < NUM_REGS) begin
      regs[dst] = val[31:0];
      r.write_value = val[31:0];
      r.wrote = 1'b1;
    end
    return r;
  endfunction

  // Predict on each accepted instruction, compare on each accepted result.
  always @(posedge clk) begin
    step_result_t exp_r;
    step_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      skip_armed = 1'b0;
      expected_results.delete();
      fail_count = 0;
      results_seen = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_results.insert(expected_results.size(), execute_instruction(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[33:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction %h", out_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r || out_tdata[39:34] !== '0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d mismatch: expected value %h wrote %b skipped %b, got %h",
                       results_seen, exp_r.write_value, exp_r.wrote, exp_r.skipped, out_tdata);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: sim/lgp_register_machine_step_test.sv
// Testbench top for the register machine step block: drives instruction
// transactions with random gaps and stalls; depends on lgp_pkg and lgp_step_checker.
module lgp_register_machine_step_test;
  import lgp_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;
  int          results_seen;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  always #1 clk = ~clk;

  lgp_register_machine_step uut (.*);

  lgp_step_checker chk (.*);

  // Sends one instruction after a random gap, then waits for acceptance.
  // Valid stays high into the next call when that call has no gap.
  task automatic send_instruction(op_t op, logic [3:0] dst, logic [3:0] sa,
                                  logic [3:0] sb, logic [31:0] opv, bit no_gap);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {opv, sb, sa, dst, 4'(op)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 131072)) - 65536);
      3: return 32'(Q_ONE);
      4: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Receiver stalls: random per result, plus the long hold-off.
  initial begin
    int st;
    @(posedge rst_n);
    forever begin
      st = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      if (st != 0 || hold_off) begin
        out_tready <= 1'b0;
        repeat (st) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed: loads of the extremes, every operation, skips, overflows.
    send_instruction(OP_LDP, 4'd0, 4'd0, 4'd0, 32'h8000_0000, 0);
    send_instruction(OP_LDC, 4'd1, 4'd0, 4'd0, 32'h7FFF_FFFF, 0);
    send_instruction(OP_NEG, 4'd2, 4'd0, 4'd0, '0, 0);
    send_instruction(OP_ADD, 4'd3, 4'd1, 4'd1, '0, 0);
    send_instruction(OP_SUB, 4'd4, 4'd0, 4'd1, '0, 0);
    send_instruction(OP_MUL, 4'd5, 4'd1, 4'd1, '0, 0);
    send_instruction(OP_SQR, 4'd6, 4'd0, 4'd0, '0, 0);
    send_instruction(OP_DIV, 4'd7, 4'd1, 4'd9, '0, 0);
    send_instruction(OP_DIV, 4'd8, 4'd0, 4'd1, '0, 0);
    send_instruction(OP_ROOT, 4'd9, 4'd0, 4'd0, '0, 0);
    send_instruction(OP_LDC, 4'd10, 4'd0, 4'd0, 32'hFFFF_8000, 0);
    send_instruction(OP_COND, 4'd10, 4'd0, 4'd0, '0, 0);
    send_instruction(OP_COND, 4'd1, 4'd0, 4'd0, '0, 0);
    send_instruction(OP_COND, 4'd15, 4'd0, 4'd0, '0, 0);
    send_instruction(OP_NOP, 4'd0, 4'd0, 4'd0, 32'hFFFF_FFFF, 0);
    send_instruction(op_t'(4'd15), 4'd0, 4'd0, 4'd0, '0, 0);
    send_instruction(OP_MUL, 4'd11, 4'd0, 4'd1, '0, 0);
    send_instruction(OP_ROOT, 4'd12, 4'd1, 4'd1, '0, 0);
    // Long receiver hold-off while instructions keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_instruction(OP_ADD, 4'($urandom), 4'($urandom), 4'($urandom), '0, 1);
    join
    // Random: one draw in four is a load; the rest take any 4-bit opcode, undefined ones included.
    for (int i = 0; i < 800; i++) begin
      logic [3:0] c;
      c = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 1)) : 4'($urandom);
      send_instruction(op_t'(c), 4'($urandom), 4'($urandom), 4'($urandom),
                       random_value(), 0);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // Verdict once everything predicted has arrived.
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d instruction results through all opcodes, skips and saturation.",
             results_seen);
    if (fail_count == 0)
      $display("lgp_register_machine_step_test: PASS");
    else
      $display("lgp_register_machine_step_test: FAIL");
    $finish;
  end

  initial begin
    #1000000;
    $display("lgp_register_machine_step_test: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lgp_pkg.sv
rtl/lgp_ctrl.sv
rtl/lgp_dpath.sv
rtl/lgp_register_machine_step.sv
sim/lgp_step_checker.sv
sim/lgp_register_machine_step_test.sv
